>>> rtl/assert_macros.svh
// assertion macros shared by the column run complement rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/crc_pkg.sv
// shared types and constants of the column run complement unit
// no dependencies
`timescale 1ns / 1ps
package crc_pkg;

	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 4;
	localparam int BORDER_W   = 7;
	localparam int TOTAL_W    = 32;

	localparam logic [BORDER_W-1:0] BORDER_RESET = 7'd1;

	typedef enum logic [1:0] {
		REG_BORDER = 2'd0,
		REG_TOP    = 2'd1,
		REG_BOTTOM = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		GAP_FULL  = 2'd0,
		GAP_ABOVE = 2'd1,
		GAP_BELOW = 2'd2
	} gap_kind_t;

endpackage

>>> rtl/crc_apb_regs.sv
// apb register file holding border width and region rows
// depends on crc_pkg
`timescale 1ns / 1ps
module crc_apb_regs import crc_pkg::*; #(
	parameter int ROW_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [BORDER_W-1:0]   border_width,
	output logic [ROW_BITS-1:0]   region_top_row,
	output logic [ROW_BITS-1:0]   region_bottom_row
);

	logic [BORDER_W-1:0] border_q;
	logic [ROW_BITS-1:0] top_q;
	logic [ROW_BITS-1:0] bottom_q;
	logic                wr_en;
	reg_idx_t            idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q <= BORDER_RESET;
			top_q    <= '0;
			bottom_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_BORDER: border_q <= pwdata[BORDER_W-1:0];
				REG_TOP:    top_q    <= pwdata[ROW_BITS-1:0];
				REG_BOTTOM: bottom_q <= pwdata[ROW_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BORDER: prdata = APB_DATA_W'(border_q);
			REG_TOP:    prdata = APB_DATA_W'(top_q);
			REG_BOTTOM: prdata = APB_DATA_W'(bottom_q);
			default:    prdata = '0;
		endcase
	end

	assign border_width      = border_q;
	assign region_top_row    = top_q;
	assign region_bottom_row = bottom_q;

endmodule

>>> rtl/crc_gap_calc.sv
// gap bound calculation: maps image rows to clamped padded rows, counts points
// depends on crc_pkg
`timescale 1ns / 1ps
module crc_gap_calc import crc_pkg::*; #(
	parameter int ROW_BITS = 12
) (
	input  gap_kind_t             kind,
	input  logic [ROW_BITS-1:0]   run_top,
	input  logic [ROW_BITS-1:0]   run_bottom,
	input  logic [ROW_BITS-1:0]   prior_bottom,
	input  logic                  started,
	input  logic [BORDER_W-1:0]   border_width,
	input  logic [ROW_BITS-1:0]   region_top_row,
	input  logic [ROW_BITS-1:0]   region_bottom_row,
	output logic [ROW_BITS:0]     gap_top,
	output logic [ROW_BITS:0]     gap_bottom,
	output logic [ROW_BITS+1:0]   gap_points
);

	localparam int W = ROW_BITS + BORDER_W + 3;
	localparam logic signed [W-1:0] PAD_MAX = W'((2 ** (ROW_BITS + 1)) - 1);
	localparam logic signed [W-1:0] ONE_S   = W'(1);

	function automatic logic [ROW_BITS:0] clamp_pad(input logic signed [W-1:0] v);
		logic [ROW_BITS:0] r;
		if (v < 0)
			r = '0;
		else if (v > PAD_MAX)
			r = PAD_MAX[ROW_BITS:0];
		else
			r = v[ROW_BITS:0];
		return r;
	endfunction

	logic signed [W-1:0] rt_s, rb_s, bw_s, top_s, bot_s, prior_s;
	logic [ROW_BITS:0]   span_bottom, above_top, above_bot, below_top;
	logic [ROW_BITS+1:0] top_x, bot_x;

	assign rt_s    = $signed(W'(region_top_row));
	assign rb_s    = $signed(W'(region_bottom_row));
	assign bw_s    = $signed(W'(border_width));
	assign top_s   = $signed(W'(run_top));
	assign bot_s   = $signed(W'(run_bottom));
	assign prior_s = $signed(W'(prior_bottom));

	assign span_bottom = clamp_pad(rb_s - rt_s + bw_s + bw_s);
	assign above_top   = started ? clamp_pad(prior_s - rt_s + bw_s + ONE_S) : '0;
	assign above_bot   = clamp_pad(top_s - rt_s + bw_s - ONE_S);
	assign below_top   = clamp_pad(bot_s - rt_s + bw_s + ONE_S);

	always_comb begin
		case (kind)
			GAP_ABOVE: begin
				gap_top    = above_top;
				gap_bottom = above_bot;
			end
			GAP_BELOW: begin
				gap_top    = below_top;
				gap_bottom = span_bottom;
			end
			default: begin
				gap_top    = '0;
				gap_bottom = span_bottom;
			end
		endcase
	end

	assign top_x      = {1'b0, gap_top};
	assign bot_x      = {1'b0, gap_bottom};
	assign gap_points = (bot_x >= top_x) ? (bot_x - top_x + (ROW_BITS+2)'(1)) : '0;

endmodule

>>> rtl/column_run_complement_unit.sv
// top level of the column run complement unit: input register, result register
// depends on crc_pkg, crc_apb_regs, crc_gap_calc and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Turns a column-wise run-length region mask into the gaps between runs, in
// padded rows of a frame bordered by border_width rows above and below the
// region. An empty column gives one full-span gap; each run gives the gap
// above it, and a run flagged last_run also gives the gap below it. An item
// is registered in the input register, and its gap is worked out
// combinationally into the result register. Unless the output stalls, items
// producing one result are taken one per cycle; a last run holds the input
// register for both its gaps, as the result register delivers one gap per
// cycle. While a result waits, the input register takes one further item and
// then the input stalls. Registers lie at byte addresses 0 (border_width),
// 4 (region_top_row) and 8 (region_bottom_row); write them only while idle.
module column_run_complement_unit import crc_pkg::*; #(
	parameter int ROW_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [ROW_BITS-1:0]   run_top,
	input  logic [ROW_BITS-1:0]   run_bottom,
	input  logic                  last_run,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ROW_BITS:0]     gap_top,
	output logic [ROW_BITS:0]     gap_bottom,
	output logic [ROW_BITS+1:0]   gap_points,
	output logic                  end_of_column,
	output logic [ROW_BITS+1:0]   column_nodes,
	output logic [TOTAL_W-1:0]    total_points
);

	logic [BORDER_W-1:0] border_width;
	logic [ROW_BITS-1:0] region_top_row;
	logic [ROW_BITS-1:0] region_bottom_row;

	crc_apb_regs #(.ROW_BITS(ROW_BITS)) u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.border_width      (border_width),
		.region_top_row    (region_top_row),
		.region_bottom_row (region_bottom_row)
	);

	// input register
	logic                valid_s1;
	logic                command_s1;
	logic [ROW_BITS-1:0] run_top_s1;
	logic [ROW_BITS-1:0] run_bottom_s1;
	logic                last_s1;
	logic                phase_q;

	// column state
	logic [ROW_BITS-1:0] prior_bottom_q;
	logic                started_q;
	logic [ROW_BITS-1:0] gap_count_q;
	logic [TOTAL_W-1:0]  point_total_q;

	// result register
	logic                out_valid_q;
	logic [ROW_BITS:0]   gap_top_q;
	logic [ROW_BITS:0]   gap_bottom_q;
	logic [ROW_BITS+1:0] gap_points_q;
	logic                eoc_q;
	logic [ROW_BITS+1:0] nodes_q;

	logic                out_adv, load, finish, accept, res_eoc;
	gap_kind_t           kind;
	logic [ROW_BITS:0]   res_top, res_bottom;
	logic [ROW_BITS+1:0] res_points;
	logic [ROW_BITS-1:0] gc_base, gc_new;
	logic [TOTAL_W:0]    sum;
	logic [TOTAL_W-1:0]  total_new;

	assign out_adv  = !out_valid_q || !out_stall;
	assign load     = valid_s1 && out_adv;
	assign res_eoc  = !command_s1 || phase_q;
	assign finish   = res_eoc || !last_s1;
	assign in_stall = valid_s1 && !(load && finish);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (!command_s1)
			kind = GAP_FULL;
		else if (phase_q)
			kind = GAP_BELOW;
		else
			kind = GAP_ABOVE;
	end

	crc_gap_calc #(.ROW_BITS(ROW_BITS)) u_calc (
		.kind              (kind),
		.run_top           (run_top_s1),
		.run_bottom        (run_bottom_s1),
		.prior_bottom      (prior_bottom_q),
		.started           (started_q),
		.border_width      (border_width),
		.region_top_row    (region_top_row),
		.region_bottom_row (region_bottom_row),
		.gap_top           (res_top),
		.gap_bottom        (res_bottom),
		.gap_points        (res_points)
	);

	assign gc_base   = command_s1 ? gap_count_q : '0;
	assign gc_new    = (&gc_base) ? gc_base : gc_base + ROW_BITS'(1);
	assign sum       = {1'b0, point_total_q} + (TOTAL_W+1)'(res_points);
	assign total_new = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (load && finish)
				valid_s1 <= 1'b0;
			if (load)
				phase_q <= !finish;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1    <= command;
			run_top_s1    <= run_top;
			run_bottom_s1 <= run_bottom;
			last_s1       <= last_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_bottom_q <= '0;
			started_q      <= 1'b0;
			gap_count_q    <= '0;
			point_total_q  <= '0;
		end else if (load) begin
			gap_count_q   <= res_eoc ? '0 : gc_new;
			started_q     <= !res_eoc;
			point_total_q <= total_new;
			if (command_s1 && !phase_q)
				prior_bottom_q <= run_bottom_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_adv)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gap_top_q    <= res_top;
			gap_bottom_q <= res_bottom;
			gap_points_q <= res_points;
			eoc_q        <= res_eoc;
			nodes_q      <= {1'b0, gc_new, 1'b0};
		end
	end

	assign out_valid     = out_valid_q;
	assign gap_top       = gap_top_q;
	assign gap_bottom    = gap_bottom_q;
	assign gap_points    = gap_points_q;
	assign end_of_column = eoc_q;
	assign column_nodes  = nodes_q;
	assign total_points  = point_total_q;

	`CRC_ASSERT(a_phase_on_last_run, clk, arst_n,
		phase_q |-> (valid_s1 && command_s1 && last_s1), "second gap phase without a last run")
	`CRC_ASSERT(a_eoc_clears_column, clk, arst_n,
		(load && res_eoc) |=> (gap_count_q == '0 && !started_q),
		"column state not cleared after final gap")
	`CRC_ASSERT(a_total_monotonic, clk, arst_n,
		load |=> (point_total_q >= $past(point_total_q)), "running point total decreased")
	`CRC_ASSERT_NEVER(a_nodes_nonzero, clk, arst_n,
		out_valid_q && (nodes_q == '0), "result with zero column nodes")
	`CRC_ASSERT(a_stall_needs_item, clk, arst_n,
		in_stall |-> (valid_s1 && !(out_adv && finish)), "input stalled without a blocked item")

endmodule
